// ===== design/ricod_pkg.sv =====
// constants for the relocation invariant code hash block
// opcodes, masks, register indexes and register reset values; no dependencies
package ricod_pkg;

    localparam int WordW  = 32;
    localparam int IndexW = 2;

    // mips major opcodes that take part in the relocation rules
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LW    = 6'h23;

    // upper half bits of a jal that survive relocation
    localparam logic [15:0] JAL_HI_MASK = 16'hFC00;

    // configuration register indexes
    localparam logic [IndexW-1:0] REG_ADDRESS_BASE = 2'd0;
    localparam logic [IndexW-1:0] REG_SEED_VALUE   = 2'd1;
    localparam logic [IndexW-1:0] REG_CHECK_WORD   = 2'd2;
    localparam logic [IndexW-1:0] REG_OFFSET_VALUE = 2'd3;

    // configuration reset values
    localparam logic [WordW-1:0] ADDRESS_BASE_RST = 32'h0000_0000;
    localparam logic [WordW-1:0] SEED_VALUE_RST   = 32'h0B11_2D28;
    localparam logic [WordW-1:0] CHECK_WORD_RST   = 32'h0000_0000;
    localparam logic [WordW-1:0] OFFSET_VALUE_RST = 32'h002A_4EB6;

    typedef logic [WordW-1:0] word_t;

endpackage

// ===== design/relocation_invariant_code_hash.sv =====
// relocation invariant code hash: top level
// sums instruction halves, removes lui pair and jal relocation fields
// each word is held in the input register, and a result in the result register; one word per cycle
// is taken unless a last word waits on a result that the result side has not yet taken
// only words marked last produce a result transfer
// reset (rst_n low, async): pipeline empty, sum and previous word cleared,
// configuration registers at their reset values
module relocation_invariant_code_hash
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  ricod_pkg::word_t     cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // [31:0] insn_word
    input  logic                 s_axis_tlast,   // last_word
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata    // [31:0] location, [63:32] raw_hash
);
    import ricod_pkg::*;

    word_t address_base_reg;
    word_t seed_value_reg;
    word_t check_word_reg;
    word_t offset_value_reg;
    word_t const_part_reg;

    logic  in_valid_reg;
    word_t in_word_reg;
    logic  in_last_reg;

    word_t sum_reg;
    word_t sum_next;
    word_t prev_word_reg;

    logic  out_valid_reg;
    word_t location_reg;
    word_t raw_hash_reg;

    logic  advance;

    logic [5:0]  cur_op;
    logic [4:0]  cur_rs;
    logic [4:0]  cur_rt;
    logic [15:0] cur_lo;
    logic [15:0] cur_hi;
    logic [5:0]  prev_op;
    logic [4:0]  prev_rt;
    logic [15:0] prev_lo;
    logic        pair_hit;
    logic        jal_hit;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_base_reg <= ADDRESS_BASE_RST;
            seed_value_reg   <= SEED_VALUE_RST;
            check_word_reg   <= CHECK_WORD_RST;
            offset_value_reg <= OFFSET_VALUE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ADDRESS_BASE: address_base_reg <= cfg_data;
                REG_SEED_VALUE:   seed_value_reg   <= cfg_data;
                REG_CHECK_WORD:   check_word_reg   <= cfg_data;
                REG_OFFSET_VALUE: offset_value_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // base + seed - check + offset, registered from the configuration registers
    always_ff @(posedge clk)
    begin
        const_part_reg <= address_base_reg + seed_value_reg - check_word_reg
                          + offset_value_reg;
    end

    // handshake: the input stage moves on unless a result would be blocked
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_word_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // instruction fields
    always_comb
    begin
        cur_op  = in_word_reg[31:26];
        cur_rs  = in_word_reg[25:21];
        cur_rt  = in_word_reg[20:16];
        cur_lo  = in_word_reg[15:0];
        cur_hi  = in_word_reg[31:16];
        prev_op = prev_word_reg[31:26];
        prev_rt = prev_word_reg[20:16];
        prev_lo = prev_word_reg[15:0];
    end

    // relocation rules and the new running sum
    always_comb
    begin
        pair_hit = (prev_op == OP_LUI) && ((cur_op == OP_ADDIU) || (cur_op == OP_LW))
                   && (cur_rs == prev_rt) && (cur_rs == cur_rt);
        jal_hit  = (cur_op == OP_JAL);
        sum_next = sum_reg + {16'd0, cur_lo} + {16'd0, cur_hi};
        if (pair_hit)
        begin
            sum_next = sum_next - {16'd0, cur_lo} - {16'd0, prev_lo};
        end
        if (jal_hit)
        begin
            sum_next = sum_next - {16'd0, cur_lo} - {16'd0, cur_hi & JAL_HI_MASK};
        end
    end

    // hash state, cleared at the end of each region
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            prev_word_reg <= '0;
        end
        else if (advance)
        begin
            sum_reg       <= in_last_reg ? '0 : sum_next;
            prev_word_reg <= in_last_reg ? '0 : in_word_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            location_reg <= const_part_reg - sum_next;
            raw_hash_reg <= sum_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {raw_hash_reg, location_reg};

endmodule

// ===== tb/relocation_invariant_code_hash_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the relocation invariant code hash block
// needs ricod_pkg and relocation_invariant_code_hash; predicts every hash on its own
module relocation_invariant_code_hash_tb;

    import ricod_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_LEN    = 400;
    localparam int DRAIN_WAIT  = 6;

    // an opcode outside both relocation rules
    localparam logic [5:0] OP_ORI = 6'h0D;

    typedef struct packed {
        word_t location;
        word_t raw_hash;
    } hash_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    word_t       cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] insn_word
    logic        s_axis_tlast = 1'b0; // last_word
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // [31:0] location, [63:32] raw_hash

    // predictor state and its copy of the registers
    word_t        region_sum = '0;
    word_t        prev_insn = '0;
    word_t        cfg_regs [4];
    hash_result_t pending_hashes [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int words_sent = 0;
    int mismatches = 0;
    int cycle_count = 0;
    hash_result_t want_res;

    relocation_invariant_code_hash uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side ready, with random stalls and an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void note_mismatch(string field, word_t want, word_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h", field, want, got);
    endfunction

    // compare each result transfer with the oldest predicted hash
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_hashes.size() == 0)
                note_mismatch("unexpected result location", '0, m_axis_tdata[31:0]);
            else
            begin
                want_res = pending_hashes.pop_front();
                if (m_axis_tdata[31:0] !== want_res.location)
                    note_mismatch("location", want_res.location, m_axis_tdata[31:0]);
                if (m_axis_tdata[63:32] !== want_res.raw_hash)
                    note_mismatch("raw_hash", want_res.raw_hash, m_axis_tdata[63:32]);
            end
        end
    end

    // fold one accepted word into the predicted hash
    task automatic fold_word(input word_t w, input logic last);
        word_t        h;
        hash_result_t r;
        h = region_sum + w[15:0] + w[31:16];
        // lui followed by addiu or lw on the same register: drop both low halves
        if (prev_insn[31:26] == OP_LUI && (w[31:26] == OP_ADDIU || w[31:26] == OP_LW)
            && w[25:21] == prev_insn[20:16] && w[25:21] == w[20:16])
            h = h - w[15:0] - prev_insn[15:0];
        // jal target bits are relocation dependent
        if (w[31:26] == OP_JAL)
            h = h - w[15:0] - (w[31:16] & JAL_HI_MASK);
        region_sum = h;
        prev_insn = w;
        if (last)
        begin
            r.location = cfg_regs[REG_ADDRESS_BASE] + cfg_regs[REG_SEED_VALUE]
                       - cfg_regs[REG_CHECK_WORD] + cfg_regs[REG_OFFSET_VALUE] - h;
            r.raw_hash = h;
            pending_hashes.push_back(r);
            region_sum = '0;
            prev_insn = '0;
        end
    endtask

    // offer one word, with random idle cycles first, until it is transferred
    task automatic send_word(input word_t w, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        fold_word(w, last);
        words_sent++;
    endtask

    // stop offering, wait for all results and for the pipeline to settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input word_t val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_regs[idx] = val;
    endtask

    task automatic write_all_regs(input word_t base, input word_t seed,
                                  input word_t check, input word_t offs);
        write_reg(REG_ADDRESS_BASE, base);
        write_reg(REG_SEED_VALUE, seed);
        write_reg(REG_CHECK_WORD, check);
        write_reg(REG_OFFSET_VALUE, offs);
    endtask

    function automatic word_t itype(input logic [5:0] op, input logic [4:0] rs,
                                    input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // one region of mostly well-formed code: lui pairs, jals, loads and noise
    task automatic send_region(input int len);
        word_t      words [$];
        word_t      w;
        int         pick;
        logic [4:0] r;
        logic [9:0] flip;
        while (words.size() < len)
        begin
            pick = $urandom_range(99);
            w = $urandom;
            if (pick < 30)
            begin
                r = 5'($urandom);
                w[31:26] = OP_LUI;
                w[20:16] = r;
                words.push_back(w);
                w = $urandom;
                w[31:26] = $urandom_range(1) ? OP_ADDIU : OP_LW;
                w[25:21] = r;
                w[20:16] = r;
                // sometimes break the register match
                if ($urandom_range(3) == 0)
                begin
                    flip = 10'd1 << $urandom_range(9);
                    w[25:16] = w[25:16] ^ flip;
                end
                words.push_back(w);
            end
            else if (pick < 45)
            begin
                w[31:26] = OP_JAL;
                words.push_back(w);
            end
            else if (pick < 55)
            begin
                w[31:26] = $urandom_range(1) ? OP_ADDIU : OP_LW;
                words.push_back(w);
            end
            else
                words.push_back(w);
        end
        foreach (words[i])
            send_word(words[i], i == words.size() - 1);
    endtask

    task automatic send_regions(input int target);
        int stop_at;
        stop_at = words_sent + target;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(9) == 0)
                send_region($urandom_range(40, 20));
            else
                send_region($urandom_range(8, 1));
        end
    endtask

    // extremes, both pair opcodes, near misses, jal, and region boundaries
    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(itype(OP_LUI, 5'd0, 5'd5, 16'h8012), 1'b0);
        send_word(itype(OP_ADDIU, 5'd5, 5'd5, 16'hFFFF), 1'b1);
        send_word(itype(OP_LUI, 5'd31, 5'd31, 16'hFFFF), 1'b0);
        send_word(itype(OP_LW, 5'd31, 5'd31, 16'hFFFF), 1'b1);
        // rs matches lui but not its own rt, then rs differs from lui rt
        send_word(itype(OP_LUI, 5'd0, 5'd7, 16'h1234), 1'b0);
        send_word(itype(OP_ADDIU, 5'd7, 5'd8, 16'h5678), 1'b0);
        send_word(itype(OP_LUI, 5'd0, 5'd3, 16'h0040), 1'b0);
        send_word(itype(OP_LW, 5'd2, 5'd2, 16'h7FFC), 1'b0);
        // lui followed by an unrelated opcode
        send_word(itype(OP_LUI, 5'd0, 5'd6, 16'hABCD), 1'b0);
        send_word(itype(OP_ORI, 5'd6, 5'd6, 16'h00FF), 1'b1);
        // lui as last word, pair partner opens the next region
        send_word(itype(OP_LUI, 5'd0, 5'd9, 16'h8000), 1'b1);
        send_word(itype(OP_ADDIU, 5'd9, 5'd9, 16'h0010), 1'b1);
        // jal with full and empty targets, and jal right after a lui
        send_word({OP_JAL, 26'h3FF_FFFF}, 1'b0);
        send_word({OP_JAL, 26'h000_0000}, 1'b1);
        send_word(itype(OP_LUI, 5'd0, 5'd2, 16'h8030), 1'b0);
        send_word({OP_JAL, 26'h20C_0040}, 1'b1);
        // back-to-back lui, the second one pairs
        send_word(itype(OP_LUI, 5'd0, 5'd4, 16'h1111), 1'b0);
        send_word(itype(OP_LUI, 5'd0, 5'd4, 16'h2222), 1'b0);
        send_word(itype(OP_ADDIU, 5'd4, 5'd4, 16'h3333), 1'b1);
        // register zero pair
        send_word(itype(OP_LUI, 5'd0, 5'd0, 16'hFFFF), 1'b0);
        send_word(itype(OP_LW, 5'd0, 5'd0, 16'h8000), 1'b1);
        wait_idle();
    endtask

    // all-zero and all-one register settings
    task automatic test_config_extremes();
        write_all_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_regions(60);
        wait_idle();
        write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_regions(60);
        wait_idle();
    endtask

    // random regions under each idling pattern, fresh registers per phase
    task automatic test_idle_phases();
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 75, 0, 6};
        recv_pct = '{0, 0, 75, 6};
        for (int p = 0; p < 4; p++)
        begin
            write_all_regs($urandom, $urandom, $urandom, $urandom);
            send_idle_pct = send_pct[p];
            recv_stall_pct = recv_pct[p];
            send_regions(260);
            wait_idle();
        end
    endtask

    // result side held off while short regions keep coming, so input stalls
    task automatic test_backpressure_fill();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_all_regs($urandom, SEED_VALUE_RST, $urandom, OFFSET_VALUE_RST);
        hold_seq = hold_seq + 1;
        @(posedge clk);
        for (int i = 0; i < 60; i++)
            send_word($urandom, i[0]);
        wait_idle();
    endtask

    initial
    begin
        cfg_regs[REG_ADDRESS_BASE] = ADDRESS_BASE_RST;
        cfg_regs[REG_SEED_VALUE]   = SEED_VALUE_RST;
        cfg_regs[REG_CHECK_WORD]   = CHECK_WORD_RST;
        cfg_regs[REG_OFFSET_VALUE] = OFFSET_VALUE_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_config_extremes();
        test_idle_phases();
        test_backpressure_fill();

        // leftover expectations count as failures
        repeat (10) @(posedge clk);
        if (pending_hashes.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
